// ----- src/bitp_pkg.sv -----
// Shared definitions for the bounded integer text parser: character codes,
// parse modes, configuration register indexes and the digit decoder.
// No dependencies.
`default_nettype none

package bitp_pkg;

   localparam int unsigned VALUE_WIDTH_DEFAULT = 64;
   localparam int unsigned DATA_WIDTH          = 64;
   localparam int unsigned CHAR_WIDTH          = 8;
   localparam int unsigned CSR_INDEX_WIDTH     = 2;
   localparam int unsigned MODE_WIDTH          = 2;
   localparam int unsigned DIGIT_WIDTH         = 4;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_UNSIGNED_DEC = 2'd0,
      MODE_UNSIGNED_HEX = 2'd1,
      MODE_SIGNED_DEC   = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PARSE_MODE  = 2'd0,
      CSR_UPPER_BOUND = 2'd1,
      CSR_LOWER_BOUND = 2'd2
   } csr_index_type;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UP_F  = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_F = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

   localparam logic [DIGIT_WIDTH-1:0] HEX_LETTER_BASE = 4'd10;

   localparam logic [DATA_WIDTH-1:0] UPPER_BOUND_RESET = {DATA_WIDTH{1'b1}};
   localparam logic [DATA_WIDTH-1:0] LOWER_BOUND_RESET = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                   ok;
      logic [DIGIT_WIDTH-1:0] value;
   } digit_type;

   // Decodes one character as a digit of base 10, or base 16 when hex is set.
   function automatic digit_type digit_of(input logic [CHAR_WIDTH-1:0] c, input logic hex);
      digit_type d;
      logic [CHAR_WIDTH-1:0] offset;
      d      = '0;
      offset = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         offset  = c - CHAR_ZERO;
         d.ok    = 1'b1;
         d.value = offset[DIGIT_WIDTH-1:0];
      end else if (hex && c >= CHAR_UP_A && c <= CHAR_UP_F) begin
         offset  = c - CHAR_UP_A;
         d.ok    = 1'b1;
         d.value = offset[DIGIT_WIDTH-1:0] + HEX_LETTER_BASE;
      end else if (hex && c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
         offset  = c - CHAR_LOW_A;
         d.ok    = 1'b1;
         d.value = offset[DIGIT_WIDTH-1:0] + HEX_LETTER_BASE;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- src/bounded_integer_text_parser.sv -----
// Top level of the bounded integer text parser: field state, bound check,
// result register with one skid entry. Depends on bitp_pkg.
//
// The block takes one character per clock unless the skid register is full;
// the result of a field is registered when its last character is accepted.
// Each character passes through a single registered
// step: the accumulator is scaled by 10 or 16, the digit is added and the
// sum is compared against the active bound in the same cycle, and that
// add-and-compare path sets the clock rate. Two result entries (an output
// register and a skid register) let characters keep flowing while a result
// waits on rsp_tready. Configuration registers are read on every character;
// write them only while no field is in progress.
`default_nettype none

module bounded_integer_text_parser #(
   parameter int unsigned VALUE_WIDTH = bitp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Input stream.
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   input  wire logic [bitp_pkg::CHAR_WIDTH-1:0]      req_tdata,  // [7:0] char_code
   input  wire logic                                 req_tlast,  // last_char
   // Result stream.
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output      logic [bitp_pkg::DATA_WIDTH-1:0]      rsp_tdata,  // [63:0] value_bits
   output      logic                                 rsp_tuser,  // field_valid
   // Configuration write port.
   input  wire logic                                 csr_we,
   input  wire logic [bitp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [bitp_pkg::DATA_WIDTH-1:0]      csr_wdata
);

   import bitp_pkg::*;

   localparam int unsigned SUM_WIDTH = VALUE_WIDTH + 4;

   localparam logic [DATA_WIDTH-1:0] WIDTH_MASK =
      (VALUE_WIDTH >= DATA_WIDTH) ? {DATA_WIDTH{1'b1}}
                                  : ((DATA_WIDTH'(1) << VALUE_WIDTH) - DATA_WIDTH'(1));
   localparam logic [DATA_WIDTH-1:0] SIGNED_MAX = WIDTH_MASK >> 1;
   localparam logic [DATA_WIDTH-1:0] NEG_LIMIT  = SIGNED_MAX + DATA_WIDTH'(1);

   // Configuration registers.
   logic [MODE_WIDTH-1:0] parse_mode_ff;
   logic [DATA_WIDTH-1:0] upper_bound_ff;
   logic [DATA_WIDTH-1:0] lower_bound_ff;

   // Field state.
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic                   start_ff, start_in;
   logic                   seen_ff, seen_in;
   logic                   failed_ff, failed_in;

   // Result entries: magnitude, sign and valid flag.
   logic                   out_valid_ff, skid_valid_ff;
   logic [VALUE_WIDTH-1:0] out_mag_ff, skid_mag_ff;
   logic                   out_neg_ff, skid_neg_ff;
   logic                   out_ok_ff, skid_ok_ff;

   logic                   take_in, push, pop;
   logic                   mode_hex, mode_signed, mode_unused, is_sign;
   logic                   bad_bounds;
   logic [DATA_WIDTH-1:0]  neg_lower, limit_full;
   logic [VALUE_WIDTH-1:0] limit_w;
   logic [SUM_WIDTH-1:0]   scaled, sum;
   logic                   fits;
   digit_type              digit;
   logic                   new_ok;
   logic [VALUE_WIDTH-1:0] new_mag;
   logic                   new_neg;
   logic [DATA_WIDTH-1:0]  out_mag_full;

   assign req_tready = !skid_valid_ff;
   assign take_in    = req_tvalid && req_tready;
   assign push       = take_in && req_tlast;
   assign pop        = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_mode_ff  <= MODE_UNSIGNED_DEC;
         upper_bound_ff <= UPPER_BOUND_RESET;
         lower_bound_ff <= LOWER_BOUND_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PARSE_MODE:  parse_mode_ff  <= csr_wdata[MODE_WIDTH-1:0];
            CSR_UPPER_BOUND: upper_bound_ff <= csr_wdata;
            CSR_LOWER_BOUND: lower_bound_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Active bound for the current sign and mode, clamped to VALUE_WIDTH.
   always_comb begin
      mode_hex    = (parse_mode_ff == MODE_UNSIGNED_HEX);
      mode_signed = (parse_mode_ff == MODE_SIGNED_DEC);
      mode_unused = !(parse_mode_ff == MODE_UNSIGNED_DEC || mode_hex || mode_signed);
      bad_bounds  = upper_bound_ff[DATA_WIDTH-1] ||
                    (lower_bound_ff != '0 && !lower_bound_ff[DATA_WIDTH-1]);
      neg_lower   = '0 - lower_bound_ff;
      if (mode_signed && neg_ff) begin
         limit_full = (neg_lower > NEG_LIMIT) ? NEG_LIMIT : neg_lower;
      end else if (mode_signed) begin
         limit_full = (upper_bound_ff < SIGNED_MAX) ? upper_bound_ff : SIGNED_MAX;
      end else begin
         limit_full = (upper_bound_ff < WIDTH_MASK) ? upper_bound_ff : WIDTH_MASK;
      end
      limit_w = limit_full[VALUE_WIDTH-1:0];
   end

   // Scaling by 16 is a shift; by 10 it is 8x plus 2x. The sum never wraps,
   // so comparing it with the bound covers both the digit and overflow checks.
   always_comb begin
      digit  = digit_of(req_tdata, mode_hex);
      scaled = mode_hex ? {acc_ff, 4'b0000}
                        : ({1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0});
      sum    = scaled + SUM_WIDTH'(digit.value);
      fits   = (sum <= {4'b0000, limit_w});
   end

   always_comb begin
      is_sign   = (req_tdata == CHAR_PLUS) || (req_tdata == CHAR_MINUS);
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      start_in  = start_ff;
      seen_in   = seen_ff;
      failed_in = failed_ff;
      if (!failed_ff) begin
         start_in = 1'b0;
         priority if (mode_unused) begin
            failed_in = 1'b1;
         end else if (start_ff && is_sign) begin
            if (req_tdata == CHAR_MINUS) begin
               if (mode_signed) begin
                  neg_in = 1'b1;
               end else begin
                  failed_in = 1'b1;
               end
            end
         end else if (mode_signed && bad_bounds) begin
            failed_in = 1'b1;
         end else if (!digit.ok || !fits) begin
            failed_in = 1'b1;
         end else begin
            acc_in  = sum[VALUE_WIDTH-1:0];
            seen_in = 1'b1;
         end
      end
      new_ok  = !failed_in && seen_in;
      new_mag = new_ok ? acc_in : '0;
      new_neg = new_ok && neg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         neg_ff    <= 1'b0;
         start_ff  <= 1'b1;
         seen_ff   <= 1'b0;
         failed_ff <= 1'b0;
      end else if (take_in) begin
         if (req_tlast) begin
            acc_ff    <= '0;
            neg_ff    <= 1'b0;
            start_ff  <= 1'b1;
            seen_ff   <= 1'b0;
            failed_ff <= 1'b0;
         end else begin
            acc_ff    <= acc_in;
            neg_ff    <= neg_in;
            start_ff  <= start_in;
            seen_ff   <= seen_in;
            failed_ff <= failed_in;
         end
      end
   end

   // Result entries. The skid entry only fills while the output entry is
   // held, and input is stalled while it is full.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_mag_ff <= skid_mag_ff;
            out_neg_ff <= skid_neg_ff;
            out_ok_ff  <= skid_ok_ff;
         end
      end else if (!out_valid_ff || pop) begin
         out_mag_ff <= new_mag;
         out_neg_ff <= new_neg;
         out_ok_ff  <= new_ok;
      end else if (push) begin
         skid_mag_ff <= new_mag;
         skid_neg_ff <= new_neg;
         skid_ok_ff  <= new_ok;
      end
   end

   assign out_mag_full = DATA_WIDTH'(out_mag_ff);
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_neg_ff ? ('0 - out_mag_full) : out_mag_full;
   assign rsp_tuser    = out_ok_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output entry is empty");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("invalid field result carries a nonzero value");

   a_field_cleared: assert property (@(posedge clock) disable iff (reset)
      push |=> (start_ff && !seen_ff && !failed_ff && !neg_ff && acc_ff == '0))
      else $error("field state not cleared after the last character");

   a_no_digit_zero_acc: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> (acc_ff == '0))
      else $error("accumulator nonzero before any digit was taken");

   a_neg_only_signed: assert property (@(posedge clock) disable iff (reset)
      (take_in && !failed_ff && !mode_signed) |=> ($past(neg_ff) == neg_ff || $past(req_tlast)))
      else $error("sign flag set outside signed mode");

endmodule

`default_nettype wire
